>>> rtl/bdq_pkg.sv
// package for the bounded deque with positional edit
// operation and status codes, field widths, default capacity; no dependencies
package bdq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VALUE_W      = 32;
    localparam int POS_W        = 5;
    localparam int COUNT_W      = 5;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_INSERT     = 3'd4,
        OP_REMOVE     = 3'd5,
        OP_READ       = 3'd6,
        OP_NONE       = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0]         operation;
        logic [VALUE_W-1:0] value_in;
        logic [POS_W-1:0]   position;
    } req_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value_out;
        logic [1:0]         status;
        logic [VALUE_W-1:0] front_value;
        logic [VALUE_W-1:0] back_value;
        logic [COUNT_W-1:0] element_count;
    } rsp_t;

endpackage

>>> rtl/bdq_if.sv
// valid/ready channel interfaces for requests and results
// depends on bdq_pkg
interface bdq_req_if;
    logic                      valid;
    logic                      ready;
    logic [2:0]                operation;
    logic signed [31:0]        value_in;
    logic [bdq_pkg::POS_W-1:0] position;
    modport source (output valid, operation, value_in, position, input ready);
    modport sink (input valid, operation, value_in, position, output ready);
endinterface

interface bdq_rsp_if;
    logic                        valid;
    logic                        ready;
    logic signed [31:0]          value_out;
    logic [1:0]                  status;
    logic signed [31:0]          front_value;
    logic signed [31:0]          back_value;
    logic [bdq_pkg::COUNT_W-1:0] element_count;
    modport source (output valid, value_out, status, front_value, back_value,
                    element_count, input ready);
    modport sink (input valid, value_out, status, front_value, back_value,
                  element_count, output ready);
endinterface

>>> rtl/bounded_deque_with_positional_edit_top.sv
// top level of the bounded deque with positional edit: sequencer and element memory
// depends on bdq_pkg and the channel interfaces in bdq_if.sv
//
// A request takes one transfer on req and gives one result transfer on rsp.
// Elements live in a circular memory of CAPACITY words with a registered
// read port. Every request passes from its transfer to a valid result through
// the accept step, a front read, a back read and a done step. Insert and
// remove first run a shift that reads, then writes, each element moved, plus
// a closing step, with up to CAPACITY-1 elements moved. End operations, reads
// and rejected requests skip the shift. The result then needs its own
// transfer before the next request is taken. Only one request is in flight;
// the next transfer is taken once the result register is free.
module bounded_deque_with_positional_edit_top #(
    parameter int CAPACITY = bdq_pkg::CAPACITY_DEF
) (
    input  logic clk,
    input  logic rst_n,
    bdq_req_if.sink   req,
    bdq_rsp_if.source rsp
);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int OW = bdq_pkg::COUNT_W;
    localparam int VW = bdq_pkg::VALUE_W;
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE, S_SHIFT_RD, S_SHIFT_WR, S_FRONT_RD, S_BACK_RD, S_DONE
    } state_t;

    // element memory, one read and one write port
    logic [VW-1:0] mem [CAPACITY];
    logic [AW-1:0] rd_addr;
    logic          rd_en;
    logic [VW-1:0] rd_data;
    logic [AW-1:0] wr_addr;
    logic          wr_en;
    logic [VW-1:0] wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

    state_t        state_reg;
    logic [AW-1:0] first_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg;      // logical index being shifted
    logic [CW-1:0] stop_reg;     // shift end index
    logic          ins_reg;      // insert shifts up, remove shifts down
    logic          grab_reg;     // capture rd_data as value_out next cycle
    logic [VW-1:0] val_reg;
    logic [VW-1:0] out_reg;
    logic [1:0]    status_reg;
    logic [VW-1:0] front_reg;
    logic          rsp_valid_reg;

    // logical index to memory slot, modulo capacity by one compare/subtract
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] first,
                                           input logic [CW-1:0] lidx);
        logic [CW:0] s;
        begin
            s = {{(CW+1-AW){1'b0}}, first} + {1'b0, lidx};
            if (s >= {1'b0, CAP})
            begin
                s = s - {1'b0, CAP};
            end
            slot = s[AW-1:0];
        end
    endfunction

    // position beyond any count the store can hold
    logic          pos_big;
    logic [CW-1:0] pos_w;
    assign pos_big = (32'(req.position) > 32'(CAPACITY));
    assign pos_w   = pos_big ? CAP : CW'(req.position);

    assign req.ready = (state_reg == S_IDLE) && !rsp_valid_reg;

    // combinational memory port control
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = val_reg;
        unique case (state_reg)
            S_SHIFT_RD:
            begin
                rd_en = 1'b1;
                rd_addr = ins_reg ? slot(first_reg, idx_reg - CW'(1))
                                  : slot(first_reg, idx_reg + CW'(1));
            end
            S_SHIFT_WR:
            begin
                wr_en = 1'b1;
                wr_addr = slot(first_reg, idx_reg);
                wr_data = rd_data;
            end
            S_FRONT_RD:
            begin
                rd_en = 1'b1;
                rd_addr = first_reg;
            end
            S_BACK_RD:
            begin
                rd_en = 1'b1;
                rd_addr = slot(first_reg, count_reg - CW'(1));
            end
            default:
            begin
            end
        endcase
        if (state_reg == S_IDLE && req.valid && req.ready)
        begin
            unique case (bdq_pkg::op_t'(req.operation))
                bdq_pkg::OP_PUSH_FRONT:
                begin
                    wr_en = (count_reg < CAP);
                    wr_addr = slot(first_reg, CAP - CW'(1));
                    wr_data = req.value_in;
                end
                bdq_pkg::OP_PUSH_BACK:
                begin
                    wr_en = (count_reg < CAP);
                    wr_addr = slot(first_reg, count_reg);
                    wr_data = req.value_in;
                end
                bdq_pkg::OP_POP_FRONT, bdq_pkg::OP_READ, bdq_pkg::OP_REMOVE:
                begin
                    rd_en = 1'b1;
                    rd_addr = (bdq_pkg::op_t'(req.operation) == bdq_pkg::OP_POP_FRONT)
                              ? first_reg : slot(first_reg, pos_w - CW'(1));
                end
                bdq_pkg::OP_POP_BACK:
                begin
                    rd_en = 1'b1;
                    rd_addr = slot(first_reg, count_reg - CW'(1));
                end
                default:
                begin
                end
            endcase
        end
        // insert: final write of the new value once the shift is done
        if (state_reg == S_SHIFT_RD && ins_reg && idx_reg == stop_reg)
        begin
            rd_en = 1'b0;
            wr_en = 1'b1;
            wr_addr = slot(first_reg, idx_reg);
            wr_data = val_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            first_reg     <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            idx_reg       <= '0;
            stop_reg      <= '0;
            ins_reg       <= 1'b0;
            grab_reg      <= 1'b0;
            val_reg       <= '0;
            out_reg       <= '0;
            front_reg     <= '0;
            status_reg    <= bdq_pkg::ST_OK;
        end
        else
        begin
            if (rsp_valid_reg && rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (grab_reg)
            begin
                out_reg  <= rd_data;
                grab_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid && req.ready)
                    begin
                        out_reg    <= '0;
                        status_reg <= bdq_pkg::ST_OK;
                        val_reg    <= req.value_in;
                        state_reg  <= S_FRONT_RD;
                        unique case (bdq_pkg::op_t'(req.operation))
                            bdq_pkg::OP_PUSH_FRONT:
                            begin
                                if (count_reg >= CAP)
                                    status_reg <= bdq_pkg::ST_FULL;
                                else
                                begin
                                    first_reg <= slot(first_reg, CAP - CW'(1));
                                    count_reg <= count_reg + CW'(1);
                                end
                            end
                            bdq_pkg::OP_PUSH_BACK:
                            begin
                                if (count_reg >= CAP)
                                    status_reg <= bdq_pkg::ST_FULL;
                                else
                                    count_reg <= count_reg + CW'(1);
                            end
                            bdq_pkg::OP_POP_FRONT:
                            begin
                                if (count_reg == '0)
                                    status_reg <= bdq_pkg::ST_EMPTY;
                                else
                                begin
                                    grab_reg  <= 1'b1;
                                    first_reg <= slot(first_reg, CW'(1));
                                    count_reg <= count_reg - CW'(1);
                                end
                            end
                            bdq_pkg::OP_POP_BACK:
                            begin
                                if (count_reg == '0)
                                    status_reg <= bdq_pkg::ST_EMPTY;
                                else
                                begin
                                    grab_reg  <= 1'b1;
                                    count_reg <= count_reg - CW'(1);
                                end
                            end
                            bdq_pkg::OP_INSERT:
                            begin
                                if (count_reg >= CAP)
                                    status_reg <= bdq_pkg::ST_FULL;
                                else if (pos_big || pos_w > count_reg)
                                    status_reg <= bdq_pkg::ST_RANGE;
                                else
                                begin
                                    ins_reg   <= 1'b1;
                                    idx_reg   <= count_reg;
                                    stop_reg  <= pos_w;
                                    state_reg <= S_SHIFT_RD;
                                end
                            end
                            bdq_pkg::OP_REMOVE, bdq_pkg::OP_READ:
                            begin
                                if (count_reg == '0)
                                    status_reg <= bdq_pkg::ST_EMPTY;
                                else if (pos_big || pos_w == '0 || pos_w > count_reg)
                                    status_reg <= bdq_pkg::ST_RANGE;
                                else
                                begin
                                    grab_reg <= 1'b1;
                                    if (bdq_pkg::op_t'(req.operation) == bdq_pkg::OP_REMOVE)
                                    begin
                                        ins_reg   <= 1'b0;
                                        idx_reg   <= pos_w - CW'(1);
                                        stop_reg  <= count_reg - CW'(1);
                                        state_reg <= S_SHIFT_RD;
                                    end
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_SHIFT_RD:
                begin
                    if (ins_reg && idx_reg == stop_reg)
                    begin
                        count_reg <= count_reg + CW'(1);
                        state_reg <= S_FRONT_RD;
                    end
                    else if (!ins_reg && idx_reg == stop_reg)
                    begin
                        count_reg <= count_reg - CW'(1);
                        state_reg <= S_FRONT_RD;
                    end
                    else
                        state_reg <= S_SHIFT_WR;
                end
                S_SHIFT_WR:
                begin
                    idx_reg   <= ins_reg ? idx_reg - CW'(1) : idx_reg + CW'(1);
                    state_reg <= S_SHIFT_RD;
                end
                S_FRONT_RD:
                    state_reg <= S_BACK_RD;
                S_BACK_RD:
                begin
                    front_reg <= rd_data;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    rsp_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // back word arrives in rd_data during S_DONE and is held by the idle memory
    logic [VW-1:0] back_reg;
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE)
        begin
            back_reg <= rd_data;
        end
    end

    logic empty_out;
    assign empty_out = (count_reg == '0);

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.value_out     = out_reg;
    assign rsp.status        = status_reg;
    assign rsp.front_value   = empty_out ? '0 : front_reg;
    assign rsp.back_value    = empty_out ? '0 : back_reg;
    assign rsp.element_count = OW'(count_reg);

endmodule

>>> rtl/bdq_checker.sv
// port-level checker for the bounded deque top level, with its bind
// depends on bdq_pkg and the channel interfaces
module bdq_checker #(
    parameter int CAPACITY = bdq_pkg::CAPACITY_DEF
) (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [1:0]  status,
    input logic [4:0]  element_count,
    input logic [31:0] front_value,
    input logic [31:0] back_value
);
    // never accept a request while a result is waiting
    a_one_flight: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !req_ready) else $error("request taken with result pending");

    // a held result stays valid with its count unchanged until its transfer
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(element_count))
        else $error("result dropped");

    // empty store shows zero ends
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && element_count == 5'd0 |-> front_value == '0 && back_value == '0)
        else $error("empty store with nonzero ends");

    // full status only with a full store
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == bdq_pkg::ST_FULL |->
            element_count == 5'(CAPACITY))
        else $error("full status with room left");
endmodule

bind bounded_deque_with_positional_edit_top bdq_checker #(.CAPACITY(CAPACITY)) u_bdq_checker (
    .clk(clk), .rst_n(rst_n),
    .req_valid(req.valid), .req_ready(req.ready),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
    .status(rsp.status), .element_count(rsp.element_count),
    .front_value(rsp.front_value), .back_value(rsp.back_value)
);

>>> verif/tb_bounded_deque_with_positional_edit_top.sv
// testbench for the bounded deque with positional edit: directed and random requests
// depends on bdq_pkg, bdq_if.sv and the rtl top level
`timescale 1ns / 1ps
module tb_bounded_deque_with_positional_edit_top;

    localparam int CAP       = 16;
    localparam int WDOG_MAX  = 20000;
    localparam int HOLD_LONG = 400;

    // expected result of one request
    typedef struct {
        logic [31:0] value_out;
        logic [1:0]  status;
        logic [31:0] front_value;
        logic [31:0] back_value;
        logic [4:0]  element_count;
    } deque_result_t;

    logic clk;
    logic rst_n;

    bdq_req_if req ();
    bdq_rsp_if rsp ();

    bounded_deque_with_positional_edit_top #(.CAPACITY(CAP)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // shadow copy of the sequence, kept in logical order (index 0 is the front)
    logic [31:0]   shadow_seq[$];
    deque_result_t pending_results[$];

    int  mismatch_count;
    int  result_count;
    int  sent_count;
    int  idle_cycles;
    bit  timed_out;
    bit  hold_off;      // long receiver stall requested by the fill test
    bit  no_idle;       // stretch with no idling on either side
    int  status_seen[4];

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // predictor: apply one request to the shadow sequence and queue its result
    function automatic void predict_deque_step(logic [2:0] op, logic [31:0] val,
                                               logic [4:0] pos);
        deque_result_t r;
        int n;
        n = shadow_seq.size();
        r.value_out = '0;
        r.status    = bdq_pkg::ST_OK;
        case (op)
            bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_BACK:
            begin
                if (n >= CAP)
                    r.status = bdq_pkg::ST_FULL;
                else if (op == bdq_pkg::OP_PUSH_FRONT)
                    shadow_seq.insert(0, val);
                else
                    shadow_seq.insert(n, val);
            end
            bdq_pkg::OP_POP_FRONT, bdq_pkg::OP_POP_BACK:
            begin
                if (n == 0)
                    r.status = bdq_pkg::ST_EMPTY;
                else if (op == bdq_pkg::OP_POP_FRONT)
                begin
                    r.value_out = shadow_seq[0];
                    shadow_seq.delete(0);
                end
                else
                begin
                    r.value_out = shadow_seq[n - 1];
                    shadow_seq.delete(n - 1);
                end
            end
            bdq_pkg::OP_INSERT:
            begin
                // full is checked before the position range
                if (n >= CAP)
                    r.status = bdq_pkg::ST_FULL;
                else if (pos > n)
                    r.status = bdq_pkg::ST_RANGE;
                else
                    shadow_seq.insert(pos, val);
            end
            bdq_pkg::OP_REMOVE, bdq_pkg::OP_READ:
            begin
                if (n == 0)
                    r.status = bdq_pkg::ST_EMPTY;
                else if (pos == 0 || pos > n)
                    r.status = bdq_pkg::ST_RANGE;
                else
                begin
                    r.value_out = shadow_seq[pos - 1];
                    if (op == bdq_pkg::OP_REMOVE)
                        shadow_seq.delete(pos - 1);
                end
            end
            default: ;
        endcase
        n = shadow_seq.size();
        r.front_value   = n ? shadow_seq[0] : '0;
        r.back_value    = n ? shadow_seq[n - 1] : '0;
        r.element_count = n[4:0];
        status_seen[r.status]++;
        pending_results.insert(pending_results.size(), r);
    endfunction

    // send one request: wait out a random gap, then hold valid until the transfer
    task automatic send_request(logic [2:0] op, logic [31:0] val, logic [4:0] pos);
        while (!no_idle && $urandom_range(99) < 38)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid     <= 1'b1;
        req.operation <= op;
        req.value_in  <= val;
        req.position  <= pos;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        // transfer happened at this edge; valid stays up for a back-to-back item
        predict_deque_step(op, val, pos);
        sent_count++;
    endtask

    // receiver ready: random stalls, or a long counted hold-off on request
    initial
    begin
        int hold;
        rsp.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                rsp.ready <= 1'b0;
                for (hold = 0; hold < HOLD_LONG; hold++)
                    @(posedge clk);
                hold_off = 1'b0;
            end
            rsp.ready <= no_idle || ($urandom_range(99) >= 38);
        end
    end

    // result checker: compare each transfer with the oldest expectation
    initial
    begin
        deque_result_t e;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp.valid && rsp.ready)
            begin
                result_count++;
                if (pending_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: result with nothing expected at %0t", $realtime);
                end
                else
                begin
                    e = pending_results[0];
                    pending_results.delete(0);
                    if (rsp.value_out !== e.value_out || rsp.status !== e.status
                        || rsp.front_value !== e.front_value
                        || rsp.back_value !== e.back_value
                        || rsp.element_count !== e.element_count)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("ERROR: result %0d exp val=%h st=%0d f=%h b=%h n=%0d",
                                     result_count, e.value_out, e.status, e.front_value,
                                     e.back_value, e.element_count);
                            $display("       got val=%h st=%0d f=%h b=%h n=%0d",
                                     rsp.value_out, rsp.status, rsp.front_value,
                                     rsp.back_value, rsp.element_count);
                        end
                    end
                end
            end
        end
    end

    // watchdog: cycles without any transfer on either channel
    initial
    begin
        forever
        begin
            @(posedge clk);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WDOG_MAX)
            begin
                timed_out = 1'b1;
                $display("watchdog expired after %0d idle cycles", idle_cycles);
                $display("Verification failed");
                $finish;
            end
        end
    end

    function automatic logic [31:0] random_value();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // directed: extremes and every special case from empty to full
    task automatic test_directed();
        int i;
        send_request(bdq_pkg::OP_POP_FRONT, '0, '0);          // pop when empty
        send_request(bdq_pkg::OP_POP_BACK, '0, '0);
        send_request(bdq_pkg::OP_REMOVE, '0, 5'd1);           // remove when empty
        send_request(bdq_pkg::OP_READ, '0, 5'd1);             // read when empty
        send_request(bdq_pkg::OP_INSERT, 32'h1234_5678, 5'd1); // insert past the end
        send_request(bdq_pkg::OP_INSERT, 32'h8000_0000, 5'd0); // insert at front of empty
        send_request(bdq_pkg::OP_PUSH_BACK, 32'h7fff_ffff, '0);
        send_request(bdq_pkg::OP_PUSH_FRONT, 32'hffff_ffff, '0);
        send_request(bdq_pkg::OP_INSERT, 32'h5555_aaaa, 5'd3); // insert at count appends
        send_request(bdq_pkg::OP_READ, '0, 5'd0);             // position zero
        send_request(bdq_pkg::OP_READ, '0, 5'd5);             // beyond count
        send_request(bdq_pkg::OP_REMOVE, '0, 5'd31);
        send_request(bdq_pkg::OP_READ, '0, 5'd2);
        send_request(bdq_pkg::OP_REMOVE, '0, 5'd2);
        send_request(bdq_pkg::OP_NONE, 32'hdead_beef, 5'd31); // unused code
        for (i = 0; i < 13; i++)
            send_request(bdq_pkg::OP_PUSH_BACK, $urandom, '0);
        send_request(bdq_pkg::OP_PUSH_FRONT, 32'h1, '0);      // push when full
        send_request(bdq_pkg::OP_INSERT, 32'h2, 5'd31);       // full wins over range
        send_request(bdq_pkg::OP_READ, '0, 5'd16);
        send_request(bdq_pkg::OP_REMOVE, '0, 5'd16);
        send_request(bdq_pkg::OP_INSERT, 32'h3, 5'd8);        // insert into the middle, filling the store
        send_request(bdq_pkg::OP_REMOVE, '0, 5'd1);
    endtask

    // fill under a long receiver stall so the block backs up its input
    task automatic test_backpressure();
        int i;
        hold_off = 1'b1;
        for (i = 0; i < 20; i++)
            send_request($urandom_range(1) ? bdq_pkg::OP_PUSH_BACK : bdq_pkg::OP_INSERT,
                         random_value(), 5'($urandom_range(shadow_seq.size())));
    endtask

    // random mix: biased toward legal positions, counts walking over the whole range
    task automatic test_random(int count);
        int i;
        int n;
        int bias;
        logic [2:0] op;
        logic [4:0] pos;
        for (i = 0; i < count; i++)
        begin
            no_idle = (i >= count / 2) && (i < count / 2 + 80);
            n = shadow_seq.size();
            bias = (i / 60) % 2;        // alternate grow and shrink phases
            case ($urandom_range(9))
                0, 1: op = bias ? bdq_pkg::OP_PUSH_BACK : bdq_pkg::OP_POP_BACK;
                2:    op = bias ? bdq_pkg::OP_PUSH_FRONT : bdq_pkg::OP_POP_FRONT;
                3, 4: op = bias ? bdq_pkg::OP_INSERT : bdq_pkg::OP_REMOVE;
                5:    op = bdq_pkg::OP_READ;
                6:    op = 3'($urandom_range(7));
                default: op = 3'($urandom_range(6));
            endcase
            if ($urandom_range(9) == 0)
                pos = 5'($urandom);     // any position, mostly out of range
            else if (op == bdq_pkg::OP_INSERT)
                pos = 5'($urandom_range(n));
            else
                pos = (n == 0) ? 5'd1 : 5'($urandom_range(n, 1));
            send_request(op, random_value(), pos);
        end
        no_idle = 1'b0;
    endtask

    // wait until every expected result has arrived, plus a drain margin
    task automatic wait_drained();
        int i;
        req.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        for (i = 0; i < 4 * CAP; i++)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        req.valid     <= 1'b0;
        req.operation <= bdq_pkg::OP_NONE;
        req.value_in  <= '0;
        req.position  <= '0;
        for (int i = 0; i < 10; i++)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_random(610);
        wait_drained();

        $display("covered %0d requests, %0d results; ok/empty/full/range %0d/%0d/%0d/%0d",
                 sent_count, result_count, status_seen[0], status_seen[1],
                 status_seen[2], status_seen[3]);
        $display("end pushes and pops, positional insert, remove and read, stalls both sides");
        if (mismatch_count == 0 && !timed_out)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> bounded_deque_with_positional_edit_top.f
rtl/bdq_pkg.sv
rtl/bdq_if.sv
rtl/bounded_deque_with_positional_edit_top.sv
rtl/bdq_checker.sv
verif/tb_bounded_deque_with_positional_edit_top.sv
